// ----- rtl/core/ssc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssc_pkg
// Shared types and constants of the sphere-sphere contact point block.
// ----------------------------------------------------------------------------
package ssc_pkg;

  localparam int FIFO_DEPTH = 4;
  localparam int DIV_STEPS  = 32;

  // front-end word: centres of the first sphere, centre differences, first radius and radius sum
  typedef struct packed {
    logic [2:0][31:0] a;
    logic [2:0][32:0] d;
    logic [30:0]      r1;
    logic [31:0]      s;
  } front_t;

  // one stage of the contact-point divider pipeline
  typedef struct packed {
    logic             valid;
    logic             hit;
    logic             szero;
    logic [2:0]       neg;
    logic [2:0][31:0] a;
    logic [31:0]      s;
    logic [2:0][31:0] rem;
    logic [2:0][31:0] lo;
  } div_t;

endpackage

// ----- rtl/core/ssc_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssc_front
// Accepts sphere pairs, forms centre differences and radius sum.
// ----------------------------------------------------------------------------
module ssc_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  input  logic [255:0]    in_tdata,
  output logic            push_valid,
  input  logic            push_ready,
  output ssc_pkg::front_t push_data
);

  logic            v_r;
  logic            v_nxt;
  ssc_pkg::front_t w_r;
  ssc_pkg::front_t w_nxt;
  logic [2:0][31:0] b;
  logic [2:0][31:0] a;
  logic [30:0]      r1;
  logic [30:0]      r2;

  assign a[0] = in_tdata[31:0];
  assign a[1] = in_tdata[63:32];
  assign a[2] = in_tdata[95:64];
  assign r1   = in_tdata[126:96];
  assign b[0] = in_tdata[158:127];
  assign b[1] = in_tdata[190:159];
  assign b[2] = in_tdata[222:191];
  assign r2   = in_tdata[253:223];

  assign in_tready  = !v_r || push_ready;
  assign push_valid = v_r;
  assign push_data  = w_r;

  always_comb begin
    v_nxt = v_r;
    w_nxt = w_r;
    if (in_tready) begin
      v_nxt = in_tvalid;
      w_nxt.a  = a;
      w_nxt.r1 = r1;
      w_nxt.s  = {1'b0, r1} + {1'b0, r2};
      for (int i = 0; i < 3; i++) begin
        w_nxt.d[i] = {b[i][31], b[i]} - {a[i][31], a[i]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= v_nxt;
    end
    w_r <= w_nxt;
  end

endmodule

// ----- rtl/core/ssc_fifo.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssc_fifo
// Short queue between front end and back end, with a registered head word.
// ----------------------------------------------------------------------------
module ssc_fifo #(
  parameter int DEPTH = ssc_pkg::FIFO_DEPTH
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push_valid,
  output logic            push_ready,
  input  ssc_pkg::front_t push_data,
  output logic            pop_valid,
  input  logic            pop,
  output ssc_pkg::front_t pop_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  ssc_pkg::front_t mem [DEPTH];
  ssc_pkg::front_t head_r;
  logic        head_v_r, head_v_nxt;
  logic [AW:0] wp_r, wp_nxt;
  logic [AW:0] rp_r, rp_nxt;
  logic [AW:0] cnt;
  logic        do_push;
  logic        do_load;

  assign cnt        = wp_r - rp_r;
  assign push_ready = (cnt != (AW+1)'(DEPTH));
  assign do_push    = push_valid && push_ready;
  assign do_load    = (cnt != '0) && (!head_v_r || pop);
  assign pop_valid  = head_v_r;
  assign pop_data   = head_r;

  always_comb begin
    wp_nxt     = wp_r;
    rp_nxt     = rp_r;
    head_v_nxt = head_v_r;
    if (do_push) begin
      wp_nxt = (wp_r[AW-1:0] == AW'(DEPTH - 1)) ? {~wp_r[AW], {AW{1'b0}}} : wp_r + 1'b1;
    end
    if (pop) begin
      head_v_nxt = 1'b0;
    end
    if (do_load) begin
      rp_nxt     = (rp_r[AW-1:0] == AW'(DEPTH - 1)) ? {~rp_r[AW], {AW{1'b0}}} : rp_r + 1'b1;
      head_v_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r     <= '0;
      rp_r     <= '0;
      head_v_r <= 1'b0;
    end else begin
      wp_r     <= wp_nxt;
      rp_r     <= rp_nxt;
      head_v_r <= head_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wp_r[AW-1:0]] <= push_data;
    end
    if (do_load) begin
      head_r <= mem[rp_r[AW-1:0]];
    end
  end

endmodule

// ----- rtl/core/ssc_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssc_back
// Squares, hit compare, pipelined contact-point divider and output register.
// ----------------------------------------------------------------------------
module ssc_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            pop_valid,
  output logic            pop,
  input  ssc_pkg::front_t pop_data,
  output logic            out_tvalid,
  input  logic            out_tready,
  output logic [95:0]     out_tdata,
  output logic            out_tuser
);

  localparam int N = ssc_pkg::DIV_STEPS;

  function automatic logic [63:0] div_step(input logic [31:0] rem, input logic [31:0] lo,
                                           input logic [31:0] s);
    logic [32:0] t;
    logic [32:0] df;
    t  = {rem, lo[31]};
    df = t - {1'b0, s};
    if (!df[32] || t[32]) begin
      return {df[31:0], lo[30:0], 1'b1};
    end
    return {t[31:0], lo[30:0], 1'b0};
  endfunction

  logic en;

  logic             s1_valid_r;
  logic [2:0][64:0] s1_sq_r;
  logic [2:0][63:0] s1_prod_r;
  logic [63:0]      s1_ssq_r;
  logic [2:0][31:0] s1_a_r;
  logic [2:0]       s1_neg_r;
  logic [31:0]      s1_s_r;

  logic [2:0][31:0] mag;
  logic [2:0][63:0] sq_w;
  logic [2:0][63:0] prod_w;
  logic [63:0]      ssq_w;
  logic [66:0]      sum;

  ssc_pkg::div_t dv_r [N+1];
  ssc_pkg::div_t dv_nxt [N+1];

  logic             out_valid_r;
  logic             out_hit_r;
  logic [2:0][31:0] out_c_r;
  logic [2:0][31:0] c_nxt;

  assign en  = !out_valid_r || out_tready;
  assign pop = en && pop_valid;

  // centre differences stay below 2^32 in magnitude
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag[i]    = pop_data.d[i][32] ? 32'(33'd0 - pop_data.d[i]) : pop_data.d[i][31:0];
      sq_w[i]   = 64'(mag[i]) * 64'(mag[i]);
      prod_w[i] = 64'(mag[i]) * 64'(pop_data.r1);
    end
    ssq_w = 64'(pop_data.s) * 64'(pop_data.s);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (en) begin
      s1_valid_r <= pop_valid;
    end
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s1_sq_r[i]   <= {1'b0, sq_w[i]};
        s1_prod_r[i] <= prod_w[i];
        s1_a_r[i]    <= pop_data.a[i];
        s1_neg_r[i]  <= pop_data.d[i][32];
      end
      s1_ssq_r <= ssq_w;
      s1_s_r   <= pop_data.s;
    end
  end

  assign sum = {2'b0, s1_sq_r[0]} + {2'b0, s1_sq_r[1]} + {2'b0, s1_sq_r[2]};

  always_comb begin
    dv_nxt[0].valid = s1_valid_r;
    dv_nxt[0].hit   = (sum <= {3'b0, s1_ssq_r});
    dv_nxt[0].szero = (s1_s_r == '0);
    dv_nxt[0].neg   = s1_neg_r;
    dv_nxt[0].a     = s1_a_r;
    dv_nxt[0].s     = s1_s_r;
    for (int i = 0; i < 3; i++) begin
      dv_nxt[0].rem[i] = s1_prod_r[i][63:32];
      dv_nxt[0].lo[i]  = s1_prod_r[i][31:0];
    end
  end

  for (genvar k = 0; k < N; k++) begin : g_div
    always_comb begin
      dv_nxt[k+1] = dv_r[k];
      for (int i = 0; i < 3; i++) begin
        {dv_nxt[k+1].rem[i], dv_nxt[k+1].lo[i]} =
          div_step(dv_r[k].rem[i], dv_r[k].lo[i], dv_r[k].s);
      end
    end
  end

  for (genvar k = 0; k <= N; k++) begin : g_stage
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_r[k].valid <= 1'b0;
      end else if (en) begin
        dv_r[k].valid <= dv_nxt[k].valid;
      end
      if (en) begin
        dv_r[k].hit   <= dv_nxt[k].hit;
        dv_r[k].szero <= dv_nxt[k].szero;
        dv_r[k].neg   <= dv_nxt[k].neg;
        dv_r[k].a     <= dv_nxt[k].a;
        dv_r[k].s     <= dv_nxt[k].s;
        dv_r[k].rem   <= dv_nxt[k].rem;
        dv_r[k].lo    <= dv_nxt[k].lo;
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (!dv_r[N].hit) begin
        c_nxt[i] = '0;
      end else if (dv_r[N].szero) begin
        c_nxt[i] = dv_r[N].a[i];
      end else if (dv_r[N].neg[i]) begin
        c_nxt[i] = dv_r[N].a[i] - dv_r[N].lo[i];
      end else begin
        c_nxt[i] = dv_r[N].a[i] + dv_r[N].lo[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= dv_r[N].valid;
    end
    if (en) begin
      out_hit_r <= dv_r[N].hit;
      out_c_r   <= c_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_hit_r;
  assign out_tdata  = {out_c_r[2], out_c_r[1], out_c_r[0]};

endmodule

// ----- rtl/core/sphere_sphere_contact_point.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sphere_sphere_contact_point
// Sphere-sphere touch test with contact point, signed Q16.16.
// ----------------------------------------------------------------------------
// Input channel in_*: one word per sphere pair (centres and radii).
// Output channel out_*: one word per pair; out_tuser is the hit flag,
// out_tdata holds the contact point (all zero when there is no hit).
// Throughput: one pair per cycle while the receiver does not stall, set by the
// fully pipelined back end (squares, compare, then a 32-stage restoring divider,
// one quotient bit per stage, for each axis).
// Registers from input accept to output valid, in order: front register,
// queue write, queue head register, multiply stage, compare stage,
// 32 divider stages, output register.
// Reset clears all valid flags; no word is in flight afterward.
// When the receiver stalls, the back end holds in place, the queue fills,
// and in_tready drops once the queue and front register are full; no word
// is lost or repeated.
// ----------------------------------------------------------------------------
module sphere_sphere_contact_point #(
  parameter int FIFO_DEPTH = ssc_pkg::FIFO_DEPTH
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // first_x, first_y, first_z, first_radius, second_x, second_y, second_z,
  // second_radius, zero fill
  input  logic [255:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // contact_x, contact_y, contact_z
  output logic [95:0]  out_tdata,
  // hit
  output logic         out_tuser
);

  logic            push_valid;
  logic            push_ready;
  ssc_pkg::front_t push_data;
  logic            pop_valid;
  logic            pop;
  ssc_pkg::front_t pop_data;

  ssc_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  ssc_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop        (pop),
    .pop_data   (pop_data)
  );

  ssc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .pop_valid  (pop_valid),
    .pop        (pop),
    .pop_data   (pop_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

// ----- rtl/core/ssc_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssc_checker
// Port-level checks of the sphere-sphere contact point block.
// ----------------------------------------------------------------------------
module ssc_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tready,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [95:0]  out_tdata,
  input logic         out_tuser
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output word valid right after reset");

  a_reset_ready: assert property (@(posedge clk) !rst_n |=> in_tready)
    else $error("input not ready right after reset");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata == '0)
    else $error("contact point nonzero on a miss");

  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("output word dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tuser))
    else $error("output word changed while stalled");

endmodule

bind sphere_sphere_contact_point ssc_checker u_ssc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

// ----- sim/ssc_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssc_scoreboard
// Watches both streams of the sphere contact block and checks every result.
// For each accepted pair it computes the exact touch test and contact point,
// queues the expected word and compares it with the oldest one on output.
// ----------------------------------------------------------------------------
module ssc_scoreboard (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [255:0] in_tdata,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [95:0]  out_tdata,
  input  logic         out_tuser,
  output int           errors,
  output int           pending,
  output int           hits_seen
);

  typedef struct packed {
    logic        hit;
    logic [95:0] point;
  } contact_t;

  contact_t contact_q[$];

  function automatic logic [31:0] axis_point(logic signed [31:0] a, logic signed [31:0] b,
                                             logic [31:0] r1, logic [31:0] s);
    logic signed [33:0] d;
    logic [32:0] mag;
    logic [63:0] q;
    logic signed [33:0] off;
    d = 34'(b) - 34'(a);
    mag = d < 0 ? 33'(-d) : 33'(d);
    q = (64'(mag) * 64'(r1)) / 64'(s);
    off = d < 0 ? -34'(q) : 34'(q);
    return 32'(34'(a) + off);
  endfunction

  function automatic contact_t sphere_contact(logic [255:0] w);
    logic signed [31:0] a[3], b[3];
    logic [30:0] r1, r2;
    logic signed [33:0] d;
    logic [67:0] sum;
    logic [31:0] s;
    contact_t res;
    for (int i = 0; i < 3; i++) begin
      a[i] = w[32*i +: 32];
      b[i] = w[127 + 32*i +: 32];
    end
    r1 = w[96 +: 31];
    r2 = w[223 +: 31];
    sum = '0;
    for (int i = 0; i < 3; i++) begin
      d = 34'(b[i]) - 34'(a[i]);
      sum += 68'(d) * 68'(d);
    end
    s = 32'(r1) + 32'(r2);
    res = '0;
    res.hit = sum <= 68'(64'(s) * 64'(s));
    if (res.hit) begin
      for (int i = 0; i < 3; i++)
        res.point[32*i +: 32] = (s == 0) ? a[i] : axis_point(a[i], b[i], 32'(r1), s);
    end
    return res;
  endfunction

  assign pending = contact_q.size();

  always @(posedge clk) begin
    contact_t exp_c;
    if (!rst_n) begin
      errors <= 0;
      hits_seen <= 0;
    end else begin
      if (in_tvalid && in_tready) contact_q.push_back(sphere_contact(in_tdata));
      if (out_tvalid && out_tready) begin
        if (contact_q.size() == 0) begin
          $display("%0t: unexpected word hit=%b point=%h", $time, out_tuser, out_tdata);
          errors <= errors + 1;
        end else begin
          exp_c = contact_q.pop_front();
          if (out_tuser) hits_seen <= hits_seen + 1;
          if (exp_c.hit !== out_tuser || exp_c.point !== out_tdata) begin
            $display("%0t: mismatch expected hit=%b point=%h actual hit=%b point=%h",
                     $time, exp_c.hit, exp_c.point, out_tuser, out_tdata);
            errors <= errors + 1;
          end
        end
      end
    end
  end

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the sphere-sphere contact point block.
// Drives directed edge pairs, then random touching, near and far pairs under
// changing sender and receiver idle rates; the checker scores every result.
// ----------------------------------------------------------------------------
module testbench;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [255:0] in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [95:0]  out_tdata;
  logic         out_tuser;
  int           errors, pending, hits_seen;
  int           send_idle = 0, recv_stall = 0;
  int           pairs_sent = 0;

  always #5 clk = ~clk;

  sphere_sphere_contact_point i_dut (.*);

  ssc_scoreboard i_checker (.*);

  always @(posedge clk) out_tready <= ($urandom_range(99) >= recv_stall);

  task automatic send_pair(logic [31:0] ax, ay, az, logic [30:0] r1,
                           logic [31:0] bx, by, bz, logic [30:0] r2);
    while ($urandom_range(99) < send_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {2'b0, r2, bz, by, bx, r1, az, ay, ax};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pairs_sent++;
  endtask

  task automatic random_pair();
    logic [31:0] a[3], b[3], span;
    logic [30:0] r1, r2;
    int kind, sh;
    kind = $urandom_range(9);
    sh = $urandom_range(30);
    for (int i = 0; i < 3; i++) begin
      a[i] = $urandom;
      b[i] = a[i] + (($urandom >>> sh) ^ ($urandom_range(1) ? 32'hFFFF_FFFF : 0));
    end
    r1 = 31'($urandom) >> $urandom_range(30);
    r2 = 31'($urandom) >> $urandom_range(30);
    if (kind < 6) begin
      span = 32'($urandom) >> (sh + 1);
      r1 = 31'(span);
      r2 = 31'(span) ^ 31'($urandom_range(3));
      if (kind == 0) r2 = 0;
    end else if (kind == 6) begin
      for (int i = 0; i < 3; i++) b[i] = $urandom;
    end else if (kind == 7) begin
      b = a;
      if ($urandom_range(1)) begin
        r1 = 0;
        r2 = 0;
      end
    end
    send_pair(a[0], a[1], a[2], r1, b[0], b[1], b[2], r2);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_pair(0, 0, 0, 0, 0, 0, 0, 0);
    send_pair(1, 2, 3, 0, 1, 2, 3, 0);
    send_pair(0, 0, 0, 0, 1, 0, 0, 0);
    send_pair(0, 0, 0, 31'h10000, 32'h20000, 0, 0, 31'h10000);
    send_pair(0, 0, 0, 31'h10000, 32'h20001, 0, 0, 31'h10000);
    send_pair(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 31'h7FFF_FFFF,
              32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 31'h7FFF_FFFF);
    send_pair(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 31'h7FFF_FFFF,
              32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 31'h7FFF_FFFF);
    send_pair(32'h8000_0000, 0, 0, 31'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0, 31'h7FFF_FFFF);
    send_pair(32'h8000_0000, 0, 0, 31'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0, 0);
    send_pair(32'h8000_0000, 0, 0, 0, 32'h7FFF_FFFF, 0, 0, 31'h7FFF_FFFF);
    send_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 3, 2, 1, 0, 4);
    send_pair(5, -7, 9, 31'h7FFF_FFFF, -3, 11, -13, 1);
    send_pair(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0,
              32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0);
    send_pair(0, 0, 0, 3, 0, 0, 32'hFFFF_FFF9, 4);
    send_pair(100, 100, 100, 10, 110, 110, 110, 8);
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 77; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 77; end
        default: begin send_idle = 10; recv_stall = 10; end
      endcase
      for (int n = 0; n < 335; n++) random_pair();
      if (phase == 1) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
      end
    end
    in_tvalid <= 1'b0;
    recv_stall = 0;
    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    $display("Sent %0d sphere pairs (%0d touching) under four idle/stall mixes,",
             pairs_sent, hits_seen);
    $display("including coincident, zero-radius, tangent and full-range cases.");
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Some tests failed");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/ssc_pkg.sv
rtl/core/ssc_front.sv
rtl/core/ssc_fifo.sv
rtl/core/ssc_back.sv
rtl/core/sphere_sphere_contact_point.sv
rtl/core/ssc_checker.sv
sim/ssc_checker.sv
sim/testbench.sv
